// ===== design/qasr_pkg.sv =====
// ----------------------------------------------------------------------------
// qasr_pkg
// Types and constants shared by the quote-aware substring replacer.
// ----------------------------------------------------------------------------
package qasr_pkg;

  localparam int unsigned MaxPatternBytes = 8;
  localparam int unsigned MaxReplBytes    = 8;
  localparam int unsigned EntryBytes      = 8;
  localparam int unsigned QueueDepth      = 4;

  localparam int unsigned LenW      = 4;
  localparam int unsigned WinIdxW   = $clog2(MaxPatternBytes);
  localparam int unsigned ByteIdxW  = $clog2(EntryBytes);
  localparam int unsigned QPtrW     = $clog2(QueueDepth);
  localparam int unsigned QCntW     = $clog2(QueueDepth + 1);
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;

  localparam logic [7:0] SingleQuote = 8'h27;
  localparam logic [7:0] DoubleQuote = 8'h22;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLength     = 2'd0,
    CfgPatternBytes      = 2'd1,
    CfgReplacementLength = 2'd2,
    CfgReplacementBytes  = 2'd3
  } cfg_idx_e;

  // One queued unit of output work: up to EntryBytes result bytes and the
  // end-of-string mark. A zero count with eos set means a bare end marker.
  typedef struct packed {
    logic [EntryBytes-1:0][7:0] bytes;
    logic [LenW-1:0]            cnt;
    logic                       eos;
  } qasr_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qasr_qstat_t;

endpackage

// ===== design/qasr_intf.sv =====
// ----------------------------------------------------------------------------
// qasr channel interfaces
// Valid/ready channels for input bytes, result bytes and register writes.
// ----------------------------------------------------------------------------
interface qasr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_string;

  modport source (output valid, output byte_in, output end_of_string, input ready);
  modport sink   (input valid, input byte_in, input end_of_string, output ready);
endinterface

interface qasr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       byte_valid;
  logic       last_of_string;

  modport source (output valid, output byte_out, output byte_valid,
                  output last_of_string, input ready);
  modport sink   (input valid, input byte_out, input byte_valid,
                  input last_of_string, output ready);
endinterface

interface qasr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/qasr_front.sv =====
// ----------------------------------------------------------------------------
// qasr_front
// Holds the configuration, the lookahead window and the quote state, and
// turns each accepted byte into at most one queue entry of output work.
// ----------------------------------------------------------------------------
module qasr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  qasr_in_if.sink               in_i,
  qasr_cfg_if.sink              cfg_i,
  input  qasr_pkg::qasr_qstat_t qstat_i,
  output logic                  push_o,
  output qasr_pkg::qasr_entry_t entry_o
);
  import qasr_pkg::*;

  logic [LenW-1:0]     plen_q, rlen_q;
  logic [CfgDataW-1:0] pat_q, rep_q;
  logic [WinIdxW-1:0]  count_q, count_d;
  logic                sq_q, sq_d, dq_q, dq_d;
  logic [MaxPatternBytes-1:0][7:0] win_q, win_d, win_new;

  logic [LenW-1:0] len, rlen, count_new;
  logic            accept, full, is_sq, is_dq, mism, do_match;
  logic [7:0]      front;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !qstat_i.full;
  assign accept      = in_i.valid && in_i.ready;

  always_comb begin
    len  = (plen_q > LenW'(MaxPatternBytes)) ? LenW'(MaxPatternBytes) : plen_q;
    rlen = (rlen_q > LenW'(MaxReplBytes)) ? LenW'(MaxReplBytes) : rlen_q;
    for (int k = 0; k < MaxPatternBytes; k++) begin
      win_new[k] = (WinIdxW'(k) == count_q) ? in_i.byte_in : win_q[k];
    end
    count_new = LenW'(count_q) + LenW'(1);
    full      = (len != '0) && (count_new == len);
    front     = win_new[0];
    is_sq     = (front == SingleQuote) && !dq_q;
    is_dq     = (front == DoubleQuote) && !sq_q;
    mism      = 1'b0;
    for (int k = 0; k < MaxPatternBytes; k++) begin
      if ((LenW'(k) < len) && (win_new[k] != pat_q[8*k +: 8])) begin
        mism = 1'b1;
      end
    end
    do_match = full && !is_sq && !is_dq && !sq_q && !dq_q && !mism;
  end

  // Entry bytes are either the replacement or the window in arrival order;
  // a non-matching decision takes the front byte and, at end of string, the
  // rest of the window follows it unchanged.
  always_comb begin
    entry_o.eos = in_i.end_of_string;
    entry_o.bytes = '0;
    for (int k = 0; k < EntryBytes; k++) begin
      if (k < MaxPatternBytes) begin
        entry_o.bytes[k] = win_new[k];
      end
    end
    if (len == '0) begin
      entry_o.bytes[0] = in_i.byte_in;
      entry_o.cnt      = LenW'(1);
    end else if (do_match) begin
      for (int k = 0; k < EntryBytes; k++) begin
        entry_o.bytes[k] = rep_q[8*k +: 8];
      end
      entry_o.cnt = rlen;
    end else if (in_i.end_of_string) begin
      entry_o.cnt = count_new;
    end else if (full) begin
      entry_o.cnt = LenW'(1);
    end else begin
      entry_o.cnt = '0;
    end
    push_o = accept && ((entry_o.cnt != '0) || in_i.end_of_string);
  end

  always_comb begin
    count_d = count_q;
    sq_d    = sq_q;
    dq_d    = dq_q;
    win_d   = win_q;
    if (cfg_i.valid && cfg_i.ready && (cfg_idx_e'(cfg_i.index) == CfgPatternLength)) begin
      count_d = '0;
      sq_d    = 1'b0;
      dq_d    = 1'b0;
    end else if (accept) begin
      if (in_i.end_of_string) begin
        count_d = '0;
        sq_d    = 1'b0;
        dq_d    = 1'b0;
      end else if (len != '0) begin
        if (do_match) begin
          count_d = '0;
        end else if (full) begin
          count_d = WinIdxW'(len - LenW'(1));
          for (int k = 0; k < MaxPatternBytes - 1; k++) begin
            win_d[k] = win_new[k+1];
          end
          win_d[MaxPatternBytes-1] = win_new[MaxPatternBytes-1];
          if (is_sq) sq_d = !sq_q;
          if (is_dq) dq_d = !dq_q;
        end else begin
          count_d = WinIdxW'(count_new);
          win_d   = win_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q  <= '0;
      rlen_q  <= '0;
      pat_q   <= '0;
      rep_q   <= '0;
      count_q <= '0;
      sq_q    <= 1'b0;
      dq_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      sq_q    <= sq_d;
      dq_q    <= dq_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_idx_e'(cfg_i.index))
          CfgPatternLength:     plen_q <= cfg_i.data[LenW-1:0];
          CfgPatternBytes:      pat_q  <= cfg_i.data;
          CfgReplacementLength: rlen_q <= cfg_i.data[LenW-1:0];
          CfgReplacementBytes:  rep_q  <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // The window never holds a full pattern between items.
  a_count_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len != '0) |-> (LenW'(count_q) < len))
    else $error("window count reached pattern length");

  // Both quote spans are never open at once.
  a_quotes_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sq_q && dq_q))
    else $error("both quote spans open");

endmodule

// ===== design/qasr_fifo.sv =====
// ----------------------------------------------------------------------------
// qasr_fifo
// Short queue of work entries between the front and back parts.
// ----------------------------------------------------------------------------
module qasr_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  qasr_pkg::qasr_entry_t entry_i,
  input  logic                  pop_i,
  output qasr_pkg::qasr_entry_t head_o,
  output qasr_pkg::qasr_qstat_t stat_o
);
  import qasr_pkg::*;

  qasr_entry_t           mem_q [QueueDepth];
  logic [QPtrW-1:0]      wr_q, rd_q;
  logic [QCntW-1:0]      cnt_q;

  assign stat_o.full  = (cnt_q == QCntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPtrW'(1);
      if (pop_i)  rd_q <= rd_q + QPtrW'(1);
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("queue pop while empty");

endmodule

// ===== design/qasr_back.sv =====
// ----------------------------------------------------------------------------
// qasr_back
// Expands queue entries into result items, one per cycle while out_o is
// ready, through an output register.
// ----------------------------------------------------------------------------
module qasr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qasr_pkg::qasr_entry_t head_i,
  input  qasr_pkg::qasr_qstat_t qstat_i,
  output logic                  pop_o,
  qasr_out_if.source            out_o
);
  import qasr_pkg::*;

  logic [ByteIdxW-1:0] idx_q;
  logic                vld_q;
  logic [7:0]          byte_q;
  logic                bval_q, last_q;

  logic                load, fin, bare;
  logic [LenW-1:0]     n_emit;

  assign out_o.valid          = vld_q;
  assign out_o.byte_out       = byte_q;
  assign out_o.byte_valid     = bval_q;
  assign out_o.last_of_string = last_q;

  always_comb begin
    bare   = (head_i.cnt == '0);
    n_emit = bare ? LenW'(1) : head_i.cnt;
    fin    = (LenW'(idx_q) == n_emit - LenW'(1));
    load   = !qstat_i.empty && (!vld_q || out_o.ready);
    pop_o  = load && fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        idx_q <= fin ? '0 : idx_q + ByteIdxW'(1);
      end else if (out_o.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= bare ? 8'h00 : head_i.bytes[idx_q];
      bval_q <= !bare;
      last_q <= head_i.eos && fin;
    end
  end

  // A bare end marker closes its string and carries a zero byte.
  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !bval_q) |-> (last_q && (byte_q == 8'h00)))
    else $error("bare marker without last flag");

  // The byte index returns to zero whenever an entry is retired.
  a_idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == '0))
    else $error("byte index not restarted after pop");

endmodule

// ===== design/quote_aware_substring_replacer.sv =====
// ----------------------------------------------------------------------------
// quote_aware_substring_replacer
// Streams a string through, replacing a configured pattern outside quoted
// spans, with a front classifier and a back expander joined by a queue.
// ----------------------------------------------------------------------------
//   port    role    payload
//   clk_i   clock   -
//   rst_ni  reset   asynchronous, active low
//   in_i    sink    byte_in[7:0], end_of_string
//   out_o   source  byte_out[7:0], byte_valid, last_of_string
//   cfg_i   sink    index[1:0], data[63:0]; always ready
//
// One input byte is accepted per cycle while the 4-entry work queue has room.
// Results leave one per cycle from a registered output while out_o is ready;
// an item yields up to eight, so the long-run rate follows the output count,
// set by the back expander's single byte slot. The first result of an item
// passes through the queue storage and then the output register.
// Reset clears configuration, window count, quote state, the queue pointers
// and the output valid; window bytes and queue storage are not reset.
// Output stalls fill the queue and then drop in_i.ready.
module quote_aware_substring_replacer (
  input  logic       clk_i,
  input  logic       rst_ni,
  qasr_in_if.sink    in_i,
  qasr_out_if.source out_o,
  qasr_cfg_if.sink   cfg_i
);
  import qasr_pkg::*;

  logic        push, pop;
  qasr_entry_t entry, head;
  qasr_qstat_t qstat;

  qasr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg_i),
    .qstat_i (qstat),
    .push_o  (push),
    .entry_o (entry)
  );

  qasr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (qstat)
  );

  qasr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .qstat_i (qstat),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== tb/qasr_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qasr_tb_pkg
// Scoreboard for the quote-aware substring replacer. It keeps its own copy of
// the registers, the lookahead window and the quote state, predicts the
// result bytes of each accepted input item and checks them in order.
// ----------------------------------------------------------------------------
package qasr_tb_pkg;
  import qasr_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       last;
  } out_byte_t;

  class replacer_scoreboard;
    logic [LenW-1:0] pattern_len = '0;
    logic [63:0]     pattern     = '0;
    logic [LenW-1:0] repl_len    = '0;
    logic [63:0]     repl        = '0;
    logic [7:0]      window [MaxPatternBytes];
    int unsigned     window_cnt  = 0;
    bit              in_single   = 1'b0;
    bit              in_double   = 1'b0;
    out_byte_t       expected_q [$];
    int unsigned     failures    = 0;

    function void write_register(cfg_idx_e idx, logic [63:0] value);
      case (idx)
        CfgPatternLength: begin
          // A new pattern length abandons whatever string is in progress.
          pattern_len = value[LenW-1:0];
          window_cnt  = 0;
          in_single   = 1'b0;
          in_double   = 1'b0;
        end
        CfgPatternBytes:      pattern  = value;
        CfgReplacementLength: repl_len = value[LenW-1:0];
        CfgReplacementBytes:  repl     = value;
        default: ;
      endcase
    endfunction

    function void push_byte(logic [7:0] data, logic data_valid);
      out_byte_t e;
      e.data       = data;
      e.data_valid = data_valid;
      e.last       = 1'b0;
      expected_q   = {expected_q, e};
    endfunction

    function void shift_window();
      int unsigned k;
      for (k = 1; k < window_cnt; k++) window[k-1] = window[k];
      if (window_cnt > 0) window_cnt--;
    endfunction

    // Works out the result bytes that one input item produces.
    function void replace_byte(logic [7:0] b, logic eos);
      int unsigned plen;
      int unsigned rlen;
      int unsigned n_before;
      int unsigned k;
      logic [7:0]  front;
      bit          hit;
      plen     = (pattern_len > MaxPatternBytes) ? MaxPatternBytes : pattern_len;
      rlen     = (repl_len > MaxReplBytes) ? MaxReplBytes : repl_len;
      n_before = expected_q.size();
      if (plen == 0) begin
        push_byte(b, 1'b1);
      end else begin
        if (window_cnt < MaxPatternBytes) begin
          window[window_cnt] = b;
          window_cnt++;
        end
        if (window_cnt >= plen) begin
          front = window[0];
          hit   = 1'b1;
          for (k = 0; k < plen; k++) begin
            if (window[k] != pattern[8*k +: 8]) hit = 1'b0;
          end
          if (front == SingleQuote && !in_double) begin
            in_single = ~in_single;
            push_byte(front, 1'b1);
            shift_window();
          end else if (front == DoubleQuote && !in_single) begin
            in_double = ~in_double;
            push_byte(front, 1'b1);
            shift_window();
          end else if (!in_single && !in_double && hit) begin
            for (k = 0; k < rlen; k++) push_byte(repl[8*k +: 8], 1'b1);
            window_cnt = 0;
          end else begin
            push_byte(front, 1'b1);
            shift_window();
          end
        end
      end
      if (eos) begin
        // A partial window is flushed as it stands.
        for (k = 0; k < window_cnt; k++) push_byte(window[k], 1'b1);
        window_cnt = 0;
        in_single  = 1'b0;
        in_double  = 1'b0;
        if (expected_q.size() == n_before) push_byte(8'h00, 1'b0);
        expected_q[expected_q.size()-1].last = 1'b1;
      end
    endfunction

    function void check_output_byte(logic [7:0] data, logic data_valid, logic last);
      out_byte_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: byte_out %02h byte_valid %0b last_of_string %0b",
               data, data_valid, last);
        failures++;
        return;
      end
      e = expected_q.pop_front();
      if (data !== e.data) begin
        $error("byte_out mismatch: expected %02h, actual %02h", e.data, data);
        failures++;
      end
      if (data_valid !== e.data_valid) begin
        $error("byte_valid mismatch: expected %0b, actual %0b", e.data_valid, data_valid);
        failures++;
      end
      if (last !== e.last) begin
        $error("last_of_string mismatch: expected %0b, actual %0b", e.last, last);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the quote-aware substring replacer. Directed strings cover
// pass-through, bare end markers, quoted spans and the length limits; random
// strings built around the configured pattern follow, under several register
// settings, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;
  import qasr_pkg::*;
  import qasr_tb_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned PhaseItems    = 38;
  localparam int unsigned PhasePatLen [NumPhases] = '{1, 8, 2, 3, 0, 13, 4, 5, 2, 8};
  localparam int unsigned PhaseRepLen [NumPhases] = '{0, 8, 1, 15, 3, 2, 0, 5, 9, 4};

  logic clk_i;
  logic rst_ni;

  qasr_in_if  in_if ();
  qasr_out_if out_if ();
  qasr_cfg_if cfg_if ();

  quote_aware_substring_replacer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  replacer_scoreboard sb;
  int unsigned        in_gap_pct    = 0;
  int unsigned        out_stall_pct = 0;
  logic [7:0]         text_q [$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned idle_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b, logic eos);
    int unsigned gap;
    gap = ($urandom_range(99) < in_gap_pct) ? gap_length() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid         <= 1'b1;
    in_if.byte_in       <= b;
    in_if.end_of_string <= eos;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.replace_byte(b, eos);
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Leaves the block idle: no input offered, every result out, pipeline empty.
  task automatic settle();
    release_input();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    sb.write_register(idx, value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Builds a string rich in whole and partial pattern copies and quotes.
  task automatic build_text(int unsigned target);
    int unsigned plen;
    int unsigned pick;
    int unsigned cut;
    int unsigned k;
    text_q.delete();
    plen = (sb.pattern_len > MaxPatternBytes) ? MaxPatternBytes : sb.pattern_len;
    while (text_q.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 25 && plen != 0) begin
        for (k = 0; k < plen; k++) text_q = {text_q, sb.pattern[8*k +: 8]};
      end else if (pick < 35 && plen > 1) begin
        cut = $urandom_range(1, plen - 1);
        for (k = 0; k < cut; k++) text_q = {text_q, sb.pattern[8*k +: 8]};
      end else if (pick < 50) begin
        text_q = {text_q, ($urandom_range(1) ? SingleQuote : DoubleQuote)};
      end else if (pick < 75) begin
        text_q = {text_q, 8'(8'h61 + 8'($urandom_range(2)))};
      end else begin
        text_q = {text_q, 8'($urandom_range(255))};
      end
    end
  endtask

  initial begin
    int unsigned stall;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall == 0 && $urandom_range(99) < out_stall_pct) stall = gap_length();
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        sb.check_output_byte(out_if.byte_out, out_if.byte_valid, out_if.last_of_string);
      end
    end
  end

  // Ends the run if no channel moves an item for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned p;
    int unsigned k;
    int unsigned r;
    int unsigned phase_items;
    bit          paused;
    logic [63:0] word;
    sb                  = new();
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.byte_in       = 8'h00;
    in_if.end_of_string = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CfgPatternLength;
    cfg_if.data         = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Pass-through with the reset configuration, byte extremes.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();

    // Pattern "ab" with an empty replacement: a match that ends the string
    // leaves only a bare end marker.
    write_reg(CfgPatternLength, 64'd2);
    write_reg(CfgPatternBytes, 64'h6261);
    write_reg(CfgReplacementLength, 64'd0);
    send_text("xab");
    send_text("ab");
    settle();

    // Replacement "XYZ" against quoted spans, nesting and a partial window.
    write_reg(CfgReplacementLength, 64'd3);
    write_reg(CfgReplacementBytes, 64'h5a5958);
    send_text("'ab'ab");
    send_text("\"'ab\"a");
    settle();

    // Lengths above the maximum are clamped to eight bytes.
    write_reg(CfgPatternLength, 64'd15);
    write_reg(CfgPatternBytes, 64'h0123_4567_89ab_cdef);
    write_reg(CfgReplacementLength, 64'd12);
    write_reg(CfgReplacementBytes, 64'hfedc_ba98_7654_3210);
    for (k = 0; k < MaxPatternBytes; k++) begin
      send_byte(sb.pattern[8*k +: 8], k == MaxPatternBytes - 1);
    end

    for (p = 0; p < NumPhases; p++) begin
      settle();
      word = '0;
      for (k = 0; k < MaxPatternBytes; k++) begin
        r = $urandom_range(99);
        if (r < 15) begin
          word[8*k +: 8] = $urandom_range(1) ? SingleQuote : DoubleQuote;
        end else if (r < 75) begin
          word[8*k +: 8] = 8'h61 + 8'($urandom_range(2));
        end else begin
          word[8*k +: 8] = 8'($urandom_range(255));
        end
      end
      write_reg(CfgPatternBytes, word);
      write_reg(CfgPatternLength, 64'(PhasePatLen[p]));
      write_reg(CfgReplacementLength, 64'(PhaseRepLen[p]));
      write_reg(CfgReplacementBytes, {$urandom(), $urandom()});
      in_gap_pct    = (p == 0) ? 0 : idle_pct();
      out_stall_pct = (p == 0) ? 0 : idle_pct();
      phase_items   = 0;
      paused        = 1'b0;
      while (phase_items < PhaseItems) begin
        build_text(($urandom_range(99) < 10) ? 1 : $urandom_range(2, 24));
        for (k = 0; k < text_q.size(); k++) send_byte(text_q[k], k == text_q.size() - 1);
        phase_items += text_q.size();
        // Hold the sender once per phase until every result is out.
        if (!paused && phase_items >= PhaseItems / 2) begin
          release_input();
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    settle();
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
